// ----- rtl/led_pulse_blink_effect_generator_assert.svh -----
// ----------------------------------------------------------------------------
// LED effect generator assertion macros
// Shared property macros used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef LED_PULSE_BLINK_EFFECT_GENERATOR_ASSERT_SVH
`define LED_PULSE_BLINK_EFFECT_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/lpb_pkg.sv -----
// ----------------------------------------------------------------------------
// LED effect generator package
// Types and constants shared by the effect generator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lpb_pkg;

	localparam int ROM_W = 17;
	localparam int CFG_IDX_W = 3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_MODE = 3'd0;
	localparam cfg_idx_t CFG_TINT = 3'd1;
	localparam cfg_idx_t CFG_AMPLITUDE = 3'd2;
	localparam cfg_idx_t CFG_PHASE_PER_MS = 3'd3;
	localparam cfg_idx_t CFG_DUTY = 3'd4;
	localparam cfg_idx_t CFG_INIT_PHASE = 3'd5;
	localparam cfg_idx_t CFG_MIN_INTERVAL = 3'd6;

	typedef enum logic [1:0] {
		MODE_OFF,
		MODE_SOLID,
		MODE_PULSE,
		MODE_BLINK
	} mode_t;

	localparam logic [7:0] AMPLITUDE_RST = 8'd255;
	localparam logic [31:0] PHASE_PER_MS_RST = 32'd6442451;
	localparam logic [16:0] DUTY_RST = 17'd32768;
	localparam logic [7:0] MIN_INTERVAL_RST = 8'd5;

	typedef struct packed {
		logic en;
		logic [31:0] a;
		logic [31:0] b;
	} mul_req_t;

endpackage

`default_nettype wire

// ----- rtl/lpb_sine_rom.sv -----
// ----------------------------------------------------------------------------
// Sine table
// Raised sine 0.5*(sin+1) in Q1.16, built at elaboration, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lpb_sine_rom #(
	parameter int IDX_BITS = 8
) (
	input  logic                       clk,
	input  logic [IDX_BITS-1:0]        idx,
	output logic [lpb_pkg::ROM_W-1:0]  data_q
);
	import lpb_pkg::*;

	localparam int Entries = 1 << IDX_BITS;
	localparam longint unsigned Quarter = longint'(Entries) >> 2;
	localparam longint unsigned HalfPi = 64'd1686629713;

	logic [ROM_W-1:0] tbl [Entries];

	for (genvar gi = 0; gi < Entries; gi++) begin : g_entry
		localparam longint unsigned Quad = longint'(gi) / Quarter;
		localparam longint unsigned Rem = longint'(gi) % Quarter;
		localparam longint unsigned Q = (Quad == 0 || Quad == 2) ? Rem : Quarter - Rem;
		localparam longint unsigned X = (HalfPi * Q) / Quarter;
		localparam longint unsigned T1 = ((((X * X) >> 30) * X) >> 30) / 6;
		localparam longint unsigned T2 = ((((T1 * X) >> 30) * X) >> 30) / 20;
		localparam longint unsigned T3 = ((((T2 * X) >> 30) * X) >> 30) / 42;
		localparam longint unsigned T4 = ((((T3 * X) >> 30) * X) >> 30) / 72;
		localparam longint unsigned T5 = ((((T4 * X) >> 30) * X) >> 30) / 110;
		localparam longint unsigned T6 = ((((T5 * X) >> 30) * X) >> 30) / 156;
		localparam longint unsigned Pos = X + T2 + T4 + T6;
		localparam longint unsigned Neg = T1 + T3 + T5;
		localparam longint unsigned S0 = (Pos >= Neg) ? Pos - Neg : 0;
		localparam longint unsigned S1 = (S0 + 8192) >> 14;
		localparam longint unsigned S = (S1 > 65536) ? 65536 : S1;
		localparam longint unsigned Val = (Quad < 2) ? 32768 + (S >> 1) : 32768 - (S >> 1);

		assign tbl[gi] = ROM_W'(Val);
	end

	always_ff @(posedge clk) begin
		data_q <= tbl[idx];
	end

endmodule

`default_nettype wire

// ----- rtl/lpb_mul_unit.sv -----
// ----------------------------------------------------------------------------
// Shared multiplier
// One 32 by 32 multiplier keeping the low word, result registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lpb_mul_unit (
	input  logic              clk,
	input  lpb_pkg::mul_req_t req,
	output logic [31:0]       prod_q
);
	import lpb_pkg::*;

	logic [63:0] full;

	assign full = {32'd0, req.a} * {32'd0, req.b};

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= full[31:0];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/led_pulse_blink_effect_generator.sv -----
// ----------------------------------------------------------------------------
// LED pulse and blink effect generator
// Phase accumulator driven pixel color with off, solid, sine pulse and blink.
// ----------------------------------------------------------------------------
// Channel   Handshake             Payload
// cfg       cfg_valid/cfg_ready   cfg_index, cfg_data
// in        in_valid/in_ready     now_ms
// out       out_valid/out_ready   red, green, blue
//
// An accepted tick that produces a color runs the check, advance, lookup,
// level and pick states, a scale and a store state per channel, then the
// done state; the first tick loads the phase instead of stepping it and
// skips the advance state. Every multiply goes through one shared multiplier.
// A rejected tick frees the block from the check state. The next tick is
// taken once the color sits in the output register; a full one stalls the sequencer.
// Reset clears the phase, the last tick time and the started flag, and
// loads the register defaults. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module led_pulse_blink_effect_generator #(
	parameter int SINE_INDEX_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  lpb_pkg::cfg_idx_t cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       now_ms,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        red,
	output logic [7:0]        green,
	output logic [7:0]        blue
);
	import lpb_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_ADVANCE,
		S_LOOKUP,
		S_LEVEL,
		S_PICK,
		S_SCALE,
		S_STORE,
		S_DONE
	} state_t;

	mode_t       mode_q;
	logic [23:0] tint_q;
	logic [7:0]  amp_q;
	logic [31:0] ppm_q;
	logic [16:0] duty_q;
	logic [31:0] init_q;
	logic [7:0]  min_q;

	state_t      state_q;
	logic        started_q;
	logic [31:0] phase_q;
	logic [31:0] last_q;
	logic [31:0] now_q;
	logic [7:0]  value_q;
	logic [1:0]  chan_q;
	logic [7:0]  ch_q [3];
	logic        out_valid_q;
	logic [7:0]  red_q;
	logic [7:0]  green_q;
	logic [7:0]  blue_q;

	logic [31:0]       elapsed;
	logic              too_soon;
	logic              blink_on;
	logic [7:0]        tint_byte;
	logic [16:0]       div_sum;
	logic [ROM_W-1:0]  rom_data;
	logic [31:0]       prod_q;
	mul_req_t          mul_req;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign red = red_q;
	assign green = green_q;
	assign blue = blue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OFF;
			tint_q <= '0;
			amp_q <= AMPLITUDE_RST;
			ppm_q <= PHASE_PER_MS_RST;
			duty_q <= DUTY_RST;
			init_q <= '0;
			min_q <= MIN_INTERVAL_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MODE: mode_q <= mode_t'(cfg_data[1:0]);
				CFG_TINT: tint_q <= cfg_data[23:0];
				CFG_AMPLITUDE: amp_q <= cfg_data[7:0];
				CFG_PHASE_PER_MS: ppm_q <= cfg_data;
				CFG_DUTY: duty_q <= cfg_data[16:0];
				CFG_INIT_PHASE: init_q <= cfg_data;
				CFG_MIN_INTERVAL: min_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign elapsed = now_q - last_q;
	assign too_soon = started_q && (elapsed < {24'd0, min_q});
	assign blink_on = {1'b0, phase_q[31:16]} < duty_q;
	// Division by 255, exact for products of two 8-bit operands.
	assign div_sum = {1'b0, prod_q[15:0]} + 17'd1 + {9'd0, prod_q[15:8]};

	always_comb begin
		case (chan_q)
			2'd0: tint_byte = tint_q[23:16];
			2'd1: tint_byte = tint_q[15:8];
			default: tint_byte = tint_q[7:0];
		endcase
	end

	always_comb begin
		mul_req = '0;
		unique case (state_q)
			S_CHECK: begin
				mul_req.en = 1'b1;
				mul_req.a = ppm_q;
				mul_req.b = elapsed;
			end
			S_LEVEL: begin
				mul_req.en = 1'b1;
				mul_req.a = 32'(rom_data);
				mul_req.b = {24'd0, amp_q};
			end
			S_SCALE: begin
				mul_req.en = 1'b1;
				mul_req.a = {24'd0, tint_byte};
				mul_req.b = {24'd0, value_q};
			end
			default: ;
		endcase
	end

	lpb_sine_rom #(
		.IDX_BITS(SINE_INDEX_BITS)
	) u_rom (
		.clk(clk),
		.idx(phase_q[31 -: SINE_INDEX_BITS]),
		.data_q(rom_data)
	);

	lpb_mul_unit u_mul (
		.clk(clk),
		.req(mul_req),
		.prod_q(prod_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			started_q <= 1'b0;
			phase_q <= '0;
			last_q <= '0;
			now_q <= '0;
			value_q <= '0;
			chan_q <= '0;
			for (int i = 0; i < 3; i++) begin
				ch_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
			red_q <= '0;
			green_q <= '0;
			blue_q <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						now_q <= now_ms;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (too_soon) begin
						state_q <= S_IDLE;
					end else begin
						last_q <= now_q;
						if (!started_q) begin
							started_q <= 1'b1;
							phase_q <= init_q;
							state_q <= S_LOOKUP;
						end else begin
							state_q <= S_ADVANCE;
						end
					end
				end
				S_ADVANCE: begin
					phase_q <= phase_q + prod_q;
					state_q <= S_LOOKUP;
				end
				S_LOOKUP: begin
					state_q <= S_LEVEL;
				end
				S_LEVEL: begin
					state_q <= S_PICK;
				end
				S_PICK: begin
					if (mode_q == MODE_PULSE) begin
						value_q <= prod_q[23:16];
					end else begin
						value_q <= blink_on ? amp_q : 8'd0;
					end
					chan_q <= 2'd0;
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					state_q <= S_STORE;
				end
				S_STORE: begin
					ch_q[chan_q] <= div_sum[15:8];
					if (chan_q == 2'd2) begin
						state_q <= S_DONE;
					end else begin
						chan_q <= chan_q + 2'd1;
						state_q <= S_SCALE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						case (mode_q)
							MODE_OFF: begin
								red_q <= '0;
								green_q <= '0;
								blue_q <= '0;
							end
							MODE_SOLID: begin
								red_q <= tint_q[23:16];
								green_q <= tint_q[15:8];
								blue_q <= tint_q[7:0];
							end
							default: begin
								red_q <= ch_q[0];
								green_q <= ch_q[1];
								blue_q <= ch_q[2];
							end
						endcase
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/lpb_checker.sv -----
// ----------------------------------------------------------------------------
// LED effect generator port checker
// Watches the top level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

`include "led_pulse_blink_effect_generator_assert.svh"

module lpb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue
);

	// A tick transaction keeps the block busy for at least the next cycle.
	`LPB_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "block ready right after accepting a tick")

	// A new color only appears as the sequencer finishes, never from idle.
	`LPB_ASSERT_NOW(a_result_from_busy, clk, arst_n, $rose(out_valid), !$past(in_ready), "color appeared while the block was idle")

	// A stalled color stays put until its transaction completes.
	`LPB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(red) && $stable(green) && $stable(blue), "stalled color changed or dropped")

endmodule

bind led_pulse_blink_effect_generator lpb_checker u_lpb_checker (.*);

`default_nettype wire
